/* rtl/core/rhsv_pkg.sv */
// ----------------------------------------------------------------------------
// rhsv_pkg: shared types and constants of the RTP hint sample validator
// Payload structs, the classified byte token passed from the front end to the
// back end, queue sizing and field limits used by the byte checks.
// ----------------------------------------------------------------------------
package rhsv_pkg;

    // Payload of one input transfer
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } in_item_t;

    // Payload of one result transfer
    typedef struct packed {
        logic        matched;
        logic [35:0] sample_length;
        logic [34:0] score_exponent;
    } out_item_t;

    // Per-byte check results computed in the front end
    typedef struct packed {
        logic is_zero;    // byte is zero (reserved header bytes)
        logic info_ok;    // version is 2, padding and extension clear
        logic mode_bad;   // entry mode above the highest known mode
        logic len_bad;    // immediate length above the limit
    } byte_flags_t;

    // One classified byte as held in the queue
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        byte_flags_t flags;
    } token_t;

    // Depth of the queue between front and back end
    localparam int QUEUE_DEPTH = 4;

    // Field limits
    localparam logic [1:0] RTP_VERSION    = 2'd2;
    localparam logic [7:0] MODE_MAX       = 8'd3;
    localparam logic [7:0] MODE_IMMEDIATE = 8'd1;
    localparam logic [7:0] IMM_LEN_MAX    = 8'd14;

    // Score increments of the base-2 likelihood exponent
    localparam logic [34:0] SCORE_BASE   = 35'd16;
    localparam logic [34:0] SCORE_PACKET = 35'd4;
    localparam logic [34:0] SCORE_ENTRY  = 35'd6;

endpackage

/* rtl/core/rhsv_front.sv */
// ----------------------------------------------------------------------------
// rhsv_front: byte intake, classification and token queue
// Accepts input bytes, evaluates the field checks on each byte and stores the
// resulting tokens in a small register queue toward the back end.
// ----------------------------------------------------------------------------
module rhsv_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rhsv_pkg::in_item_t in_item,
    output logic               tok_valid,
    input  logic               tok_ready,
    output rhsv_pkg::token_t   tok
);

    localparam int PTR_W = (rhsv_pkg::QUEUE_DEPTH > 1) ? $clog2(rhsv_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(rhsv_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(rhsv_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(rhsv_pkg::QUEUE_DEPTH);

    rhsv_pkg::token_t   queue_reg [rhsv_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    rhsv_pkg::token_t   new_tok;
    logic               push, pop;

    // Classify the incoming byte
    always_comb
    begin
        new_tok.data_byte      = in_item.data_byte;
        new_tok.first_byte     = in_item.first_byte;
        new_tok.flags.is_zero  = (in_item.data_byte == 8'd0);
        new_tok.flags.info_ok  = (in_item.data_byte[7:6] == rhsv_pkg::RTP_VERSION) &&
                                 (in_item.data_byte[1:0] == 2'b00);
        new_tok.flags.mode_bad = (in_item.data_byte > rhsv_pkg::MODE_MAX);
        new_tok.flags.len_bad  = (in_item.data_byte > rhsv_pkg::IMM_LEN_MAX);
    end

    assign in_ready  = (count_reg != CNT_FULL);
    assign tok_valid = (count_reg != '0);
    assign tok       = queue_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = tok_valid && tok_ready;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the token at the write slot
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= new_tok;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue fill count above depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == CNT_FULL) && !pop |=> (count_reg == CNT_FULL))
        else $error("queue fill count changed while full without a pop");

endmodule

/* rtl/core/rhsv_back.sv */
// ----------------------------------------------------------------------------
// rhsv_back: sample parser and result register
// Walks the sample header, packet headers and table entries one token per
// cycle unless an untaken result stalls it, keeps byte count and score
// exponent, and issues one result at the first failure or valid sample end.
// ----------------------------------------------------------------------------
module rhsv_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tok_valid,
    output logic                tok_ready,
    input  rhsv_pkg::token_t    tok,
    output logic                out_valid,
    input  logic                out_ready,
    output rhsv_pkg::out_item_t out_item
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HDR,
        PH_PKT,
        PH_ENT,
        PH_DONE
    } phase_t;

    // Byte positions within the records
    localparam logic [3:0] POS_0        = 4'd0;
    localparam logic [3:0] POS_1        = 4'd1;
    localparam logic [3:0] POS_2        = 4'd2;
    localparam logic [3:0] POS_INFO     = 4'd4;
    localparam logic [3:0] POS_CNT_HIGH = 4'd10;
    localparam logic [3:0] POS_CNT_LOW  = 4'd11;
    localparam logic [3:0] POS_ENT_LAST = 4'd15;

    phase_t              phase_reg, phase_next;
    logic [3:0]          pos_reg, pos_next;
    logic [15:0]         packets_reg, packets_next;
    logic [15:0]         entries_reg, entries_next;
    logic [7:0]          held_reg, held_next;
    logic [7:0]          mode_reg, mode_next;
    logic [36:0]         count_reg, count_next;
    logic [34:0]         score_reg, score_next;
    logic                out_valid_reg, out_valid_next;
    rhsv_pkg::out_item_t result_reg, result_next;

    phase_t              ph;
    logic [3:0]          pos;
    logic                tok_fire;
    logic                emit;
    logic                ok;
    logic                pkt_done;

    assign tok_ready = !out_valid_reg || out_ready;
    assign tok_fire  = tok_valid && tok_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = result_reg;

    // Parse one token
    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        packets_next = packets_reg;
        entries_next = entries_reg;
        held_next    = held_reg;
        mode_next    = mode_reg;
        count_next   = count_reg;
        score_next   = score_reg;
        emit         = 1'b0;
        ok           = 1'b0;
        pkt_done     = 1'b0;
        ph           = phase_reg;
        pos          = pos_reg;

        if (tok_fire)
        begin
            // restart on the first byte of a candidate
            if (tok.first_byte)
            begin
                ph           = PH_HDR;
                phase_next   = PH_HDR;
                pos          = '0;
                packets_next = '0;
                entries_next = '0;
                held_next    = '0;
                mode_next    = '0;
                count_next   = '0;
                score_next   = '0;
            end

            if (ph == PH_HDR || ph == PH_PKT || ph == PH_ENT)
            begin
                count_next = count_next + 1'b1;
                pos_next   = pos + 1'b1;
                unique case (ph)
                    PH_HDR:
                    begin
                        if (pos == POS_0)
                        begin
                            held_next = tok.data_byte;
                        end
                        else if (pos == POS_1)
                        begin
                            packets_next = {held_reg, tok.data_byte};
                        end
                        else if (pos == POS_2)
                        begin
                            if (!tok.flags.is_zero)
                            begin
                                emit = 1'b1;
                            end
                        end
                        else
                        begin
                            if (!tok.flags.is_zero)
                            begin
                                emit = 1'b1;
                            end
                            else
                            begin
                                score_next = rhsv_pkg::SCORE_BASE;
                                pos_next   = '0;
                                if (packets_reg == '0)
                                begin
                                    emit = 1'b1;
                                    ok   = 1'b1;
                                end
                                else
                                begin
                                    phase_next = PH_PKT;
                                end
                            end
                        end
                    end
                    PH_PKT:
                    begin
                        if (pos == POS_INFO)
                        begin
                            if (!tok.flags.info_ok)
                            begin
                                emit = 1'b1;
                            end
                        end
                        else if (pos == POS_CNT_HIGH)
                        begin
                            held_next = tok.data_byte;
                        end
                        else if (pos == POS_CNT_LOW)
                        begin
                            entries_next = {held_reg, tok.data_byte};
                            score_next   = score_reg + rhsv_pkg::SCORE_PACKET;
                            pos_next     = '0;
                            if ({held_reg, tok.data_byte} == 16'd0)
                            begin
                                pkt_done = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_ENT;
                            end
                        end
                    end
                    PH_ENT:
                    begin
                        if (pos == POS_0)
                        begin
                            mode_next = tok.data_byte;
                            if (tok.flags.mode_bad)
                            begin
                                emit = 1'b1;
                            end
                        end
                        else if (pos == POS_1)
                        begin
                            if (mode_reg == rhsv_pkg::MODE_IMMEDIATE && tok.flags.len_bad)
                            begin
                                emit = 1'b1;
                            end
                        end
                        else if (pos == POS_ENT_LAST)
                        begin
                            score_next   = score_reg + rhsv_pkg::SCORE_ENTRY;
                            entries_next = entries_reg - 1'b1;
                            pos_next     = '0;
                            if (entries_reg == 16'd1)
                            begin
                                pkt_done = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase

                // close the packet: finish the sample or start the next packet
                if (pkt_done)
                begin
                    packets_next = packets_reg - 1'b1;
                    pos_next     = '0;
                    if (packets_reg == 16'd1)
                    begin
                        emit = 1'b1;
                        ok   = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_PKT;
                    end
                end

                if (emit)
                begin
                    phase_next = PH_DONE;
                end
            end
        end
    end

    // Build the result and manage the output register
    always_comb
    begin
        result_next.matched        = ok;
        result_next.sample_length  = ok ? count_next[35:0] : 36'd0;
        result_next.score_exponent = ok ? score_next : 35'd0;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Hold parser state and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            pos_reg       <= '0;
            packets_reg   <= '0;
            entries_reg   <= '0;
            held_reg      <= '0;
            mode_reg      <= '0;
            count_reg     <= '0;
            score_reg     <= '0;
            out_valid_reg <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            packets_reg   <= packets_next;
            entries_reg   <= entries_next;
            held_reg      <= held_next;
            mode_reg      <= mode_next;
            count_reg     <= count_next;
            score_reg     <= score_next;
            out_valid_reg <= out_valid_next;
            if (emit)
            begin
                result_reg <= result_next;
            end
        end
    end

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result_reg.matched |->
            (result_reg.sample_length == '0) && (result_reg.score_exponent == '0))
        else $error("failure result carries nonzero length or score");

    a_match_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.matched |->
            (result_reg.sample_length >= 36'd4) &&
            (result_reg.score_exponent >= rhsv_pkg::SCORE_BASE))
        else $error("matched result below the minimum length or score");

    a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (phase_reg == PH_DONE) && out_valid_reg)
        else $error("result issued without entering the done phase");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !emit)
        else $error("new result would overwrite an untaken result");

endmodule

/* rtl/core/rtp_hint_sample_validator_core.sv */
// ----------------------------------------------------------------------------
// rtp_hint_sample_validator_core: RTP hint sample validator, top level
// Checks a candidate hint sample streamed one byte per transfer and reports
// match, byte length and base-2 score exponent at most once per candidate.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle, back to back, as long as the
// result side keeps up: the front end classifies each byte and pushes it into
// a four-entry token queue, and the back end parses one token per cycle. A
// result is registered in the output register after the byte that decides
// it has passed the token queue and the parse step; while that result waits
// to be taken the queue keeps absorbing up to four more bytes. The sustained
// rate of one byte per cycle is set by the parse step of the back end.
module rtp_hint_sample_validator_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rhsv_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output rhsv_pkg::out_item_t out_item
);

    logic             tok_valid;
    logic             tok_ready;
    rhsv_pkg::token_t tok;

    rhsv_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok       (tok)
    );

    rhsv_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok       (tok),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

/* tb/sv/rtp_hint_sample_validator_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_hint_sample_validator_core_tb: self-checking bench for the hint sample validator
// Streams candidate hint samples byte by byte: directed header, packet and
// entry checks first, then random samples with injected faults, cuts and
// stray bytes under several idle and stall mixes. A behavioral parser in the
// bench predicts each verdict, and every result transfer is compared field by
// field with the oldest prediction.
// ----------------------------------------------------------------------------
module rtp_hint_sample_validator_core_tb;

    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_TAIL  = 16;
    localparam int MAX_REPORTS = 100;
    localparam int HOLD_CYCLES = 300;

    // Parser phases of the behavioral model
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_PACKET,
        PH_ENTRY,
        PH_DONE
    } parse_phase_t;

    // Byte positions within the sample header, packet header and entry
    localparam logic [3:0] HDR_COUNT_HI = 4'd0;
    localparam logic [3:0] HDR_COUNT_LO = 4'd1;
    localparam logic [3:0] HDR_RSVD_0   = 4'd2;
    localparam logic [3:0] PKT_INFO_HI  = 4'd4;
    localparam logic [3:0] PKT_ENT_HI   = 4'd10;
    localparam logic [3:0] PKT_ENT_LO   = 4'd11;
    localparam logic [3:0] ENT_MODE     = 4'd0;
    localparam logic [3:0] ENT_LEN      = 4'd1;
    localparam logic [3:0] ENT_LAST     = 4'd15;

    localparam logic [7:0] MODE_SAMPLE  = 8'd2;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    rhsv_pkg::in_item_t  in_item   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    rhsv_pkg::out_item_t out_item;

    // Parser state of the model
    parse_phase_t phase_now  = PH_IDLE;
    logic [3:0]   rec_pos    = '0;
    logic [15:0]  pkts_left  = '0;
    logic [15:0]  ents_left  = '0;
    logic [7:0]   high_byte  = '0;
    logic [7:0]   cur_mode   = '0;
    logic [36:0]  byte_total = '0;
    logic [34:0]  score_exp  = '0;

    rhsv_pkg::out_item_t expected_verdicts[$];
    logic [7:0] frame_q[$];

    int bytes_taken    = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int hold_left      = 0;

    rtp_hint_sample_validator_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // Generate the 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("rtp_hint_sample_validator_core_tb: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Behavioral parser
    // ------------------------------------------------------------------------

    // Record the verdict of the current candidate and ignore bytes until restart
    function automatic void close_sample(input logic ok);
        rhsv_pkg::out_item_t v;
        v.matched        = ok;
        v.sample_length  = ok ? byte_total[35:0] : '0;
        v.score_exponent = ok ? score_exp : '0;
        expected_verdicts.push_back(v);
        phase_now = PH_DONE;
    endfunction

    // Finish a packet: either the sample is complete or the next packet opens
    function automatic void close_packet();
        pkts_left = pkts_left - 16'd1;
        rec_pos   = '0;
        if (pkts_left == 16'd0)
            close_sample(1'b1);
        else
            phase_now = PH_PACKET;
    endfunction

    // Advance the parser by one accepted byte
    function automatic void track_byte(input logic [7:0] b, input logic fb);
        logic [3:0] pos;
        if (fb)
        begin
            phase_now  = PH_HEADER;
            rec_pos    = '0;
            pkts_left  = '0;
            ents_left  = '0;
            high_byte  = '0;
            cur_mode   = '0;
            byte_total = '0;
            score_exp  = '0;
        end
        if (phase_now == PH_IDLE || phase_now == PH_DONE)
            return;

        byte_total = byte_total + 37'd1;
        pos        = rec_pos;
        rec_pos    = pos + 4'd1;

        case (phase_now)
            PH_HEADER:
            begin
                if (pos == HDR_COUNT_HI)
                    high_byte = b;
                else if (pos == HDR_COUNT_LO)
                    pkts_left = {high_byte, b};
                else if (b != 8'h00)
                    close_sample(1'b0);
                else if (pos != HDR_RSVD_0)
                begin
                    score_exp = rhsv_pkg::SCORE_BASE;
                    rec_pos   = '0;
                    if (pkts_left == 16'd0)
                        close_sample(1'b1);
                    else
                        phase_now = PH_PACKET;
                end
            end
            PH_PACKET:
            begin
                if (pos == PKT_INFO_HI)
                begin
                    if (b[7:6] != rhsv_pkg::RTP_VERSION || b[1:0] != 2'b00)
                        close_sample(1'b0);
                end
                else if (pos == PKT_ENT_HI)
                    high_byte = b;
                else if (pos == PKT_ENT_LO)
                begin
                    ents_left = {high_byte, b};
                    score_exp = score_exp + rhsv_pkg::SCORE_PACKET;
                    rec_pos   = '0;
                    if (ents_left == 16'd0)
                        close_packet();
                    else
                        phase_now = PH_ENTRY;
                end
            end
            default:
            begin
                if (pos == ENT_MODE)
                begin
                    cur_mode = b;
                    if (b > rhsv_pkg::MODE_MAX)
                        close_sample(1'b0);
                end
                else if (pos == ENT_LEN)
                begin
                    if (cur_mode == rhsv_pkg::MODE_IMMEDIATE && b > rhsv_pkg::IMM_LEN_MAX)
                        close_sample(1'b0);
                end
                else if (pos == ENT_LAST)
                begin
                    score_exp = score_exp + rhsv_pkg::SCORE_ENTRY;
                    ents_left = ents_left - 16'd1;
                    rec_pos   = '0;
                    if (ents_left == 16'd0)
                        close_packet();
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // Compare each result transfer with the oldest predicted verdict
    always @(posedge clk)
    begin
        rhsv_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_verdicts.size() == 0)
                report_mismatch("unexpected result", 64'(out_item.sample_length), '0);
            else
            begin
                want = expected_verdicts.pop_front();
                if (out_item.matched !== want.matched)
                    report_mismatch("matched", 64'(out_item.matched), 64'(want.matched));
                if (out_item.sample_length !== want.sample_length)
                    report_mismatch("sample_length", 64'(out_item.sample_length),
                                    64'(want.sample_length));
                if (out_item.score_exponent !== want.score_exponent)
                    report_mismatch("score_exponent", 64'(out_item.score_exponent),
                                    64'(want.score_exponent));
            end
        end
    end

    // Drive result-side ready: random stalls, or a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic logic [7:0] good_info();
        return {rhsv_pkg::RTP_VERSION, 4'($urandom), 2'b00};
    endfunction

    function automatic void put_header(input logic [15:0] npk, input logic [7:0] r2,
                                       input logic [7:0] r3);
        frame_q.push_back(npk[15:8]);
        frame_q.push_back(npk[7:0]);
        frame_q.push_back(r2);
        frame_q.push_back(r3);
    endfunction

    // Append a packet header: timestamp, info, sequence, flags, entry count
    function automatic void put_packet(input logic [15:0] nent, input logic [7:0] info_hi);
        repeat (4) frame_q.push_back(8'($urandom));
        frame_q.push_back(info_hi);
        repeat (5) frame_q.push_back(8'($urandom));
        frame_q.push_back(nent[15:8]);
        frame_q.push_back(nent[7:0]);
    endfunction

    function automatic void put_entry(input logic [7:0] mode, input logic [7:0] len);
        frame_q.push_back(mode);
        frame_q.push_back(len);
        repeat (14) frame_q.push_back(8'($urandom));
    endfunction

    // Offer one byte and hold it until the transfer; entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic fb);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_item  <= '{data_byte: b, first_byte: fb};
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        track_byte(b, fb);
        bytes_taken++;
        @(negedge clk);
    endtask

    // Send the built frame as one candidate, first byte marked
    task automatic send_frame();
        foreach (frame_q[i])
            send_byte(frame_q[i], i == 0);
        frame_q.delete();
    endtask

    task automatic send_stray(input int count);
        repeat (count) send_byte(8'($urandom), 1'b0);
    endtask

    // Stop offering bytes and wait for every predicted verdict
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Build and send one random sample, sometimes cut short or corrupted
    task automatic send_random_sample();
        int         npk;
        int         nent;
        int         kind;
        int         cut;
        logic [7:0] mode;
        logic [7:0] len;
        logic [7:0] info;
        npk = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 2);
        put_header(16'(npk),
                   ($urandom_range(19) == 0) ? 8'($urandom) : 8'h00,
                   ($urandom_range(19) == 0) ? 8'($urandom) : 8'h00);
        for (int p = 0; p < npk; p++)
        begin
            nent = $urandom_range(0, 2);
            info = ($urandom_range(9) == 0) ? 8'($urandom) : good_info();
            put_packet(16'(nent), info);
            for (int e = 0; e < nent; e++)
            begin
                mode = ($urandom_range(15) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
                if (mode == rhsv_pkg::MODE_IMMEDIATE)
                    len = ($urandom_range(9) == 0) ? 8'($urandom_range(15, 255))
                                                   : 8'($urandom_range(0, 14));
                else
                    len = 8'($urandom);
                put_entry(mode, len);
            end
        end

        // Cut the frame short or flip one byte now and then
        kind = $urandom_range(99);
        if (kind < 10)
        begin
            cut = $urandom_range(1, frame_q.size() - 1);
            while (frame_q.size() > cut)
                void'(frame_q.pop_back());
        end
        else if (kind < 20)
            frame_q[$urandom_range(1, frame_q.size() - 1)] = 8'($urandom);

        send_frame();
        if ($urandom_range(9) == 0)
            send_stray($urandom_range(1, 4));
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Bytes before any first byte and after a verdict are ignored
    task automatic test_stray_bytes();
        send_stray(3);
        put_header(16'd0, 8'h00, 8'h00);
        send_frame();
        send_stray(2);
        wait_idle();
    endtask

    // Zero packet count and nonzero reserved bytes
    task automatic test_header_checks();
        put_header(16'd0, 8'hFF, 8'h00);
        send_frame();
        put_header(16'd0, 8'h00, 8'h01);
        send_frame();
        put_header(16'd1, 8'h00, 8'h80);
        send_frame();
        wait_idle();
    endtask

    // Version, padding and extension bits of the packet info word
    task automatic test_packet_checks();
        logic [7:0] infos[8] = '{8'h80, 8'hBC, 8'h00, 8'h40, 8'hC0, 8'h81, 8'h82, 8'hFF};
        foreach (infos[i])
        begin
            put_header(16'd1, 8'h00, 8'h00);
            put_packet(16'd0, infos[i]);
            send_frame();
        end
        wait_idle();
    endtask

    // Entry modes and the immediate length limit
    task automatic test_entry_checks();
        put_header(16'd2, 8'h00, 8'h00);
        put_packet(16'd4, good_info());
        put_entry(8'd0, 8'hFF);
        put_entry(rhsv_pkg::MODE_IMMEDIATE, rhsv_pkg::IMM_LEN_MAX);
        put_entry(MODE_SAMPLE, 8'hFF);
        put_entry(rhsv_pkg::MODE_MAX, 8'h00);
        put_packet(16'd0, good_info());
        send_frame();
        put_header(16'd1, 8'h00, 8'h00);
        put_packet(16'd1, good_info());
        put_entry(rhsv_pkg::MODE_MAX + 8'd1, 8'h00);
        send_frame();
        put_header(16'd1, 8'h00, 8'h00);
        put_packet(16'd1, good_info());
        put_entry(8'hFF, 8'h00);
        send_frame();
        put_header(16'd1, 8'h00, 8'h00);
        put_packet(16'd1, good_info());
        put_entry(rhsv_pkg::MODE_IMMEDIATE, rhsv_pkg::IMM_LEN_MAX + 8'd1);
        send_frame();
        put_header(16'd1, 8'h00, 8'h00);
        put_packet(16'd1, good_info());
        put_entry(rhsv_pkg::MODE_IMMEDIATE, 8'hFF);
        send_frame();
        wait_idle();
    endtask

    // Full-scale counts dropped by a restart, and a restart inside the header
    task automatic test_restart_and_extremes();
        put_header(16'hFFFF, 8'h00, 8'h00);
        put_packet(16'd0, good_info());
        put_packet(16'd0, good_info());
        send_frame();
        put_header(16'd1, 8'h00, 8'h00);
        put_packet(16'hFFFF, good_info());
        put_entry(8'd0, 8'h00);
        put_entry(rhsv_pkg::MODE_IMMEDIATE, 8'd3);
        send_frame();
        put_header(16'hFF00, 8'h00, 8'h00);
        void'(frame_q.pop_back());
        void'(frame_q.pop_back());
        send_frame();
        put_header(16'd1, 8'h00, 8'h00);
        put_packet(16'd1, good_info());
        put_entry(MODE_SAMPLE, 8'h00);
        send_frame();
        wait_idle();
    endtask

    // Random samples under one idle and stall mix
    task automatic test_random_traffic(input int n_bytes, input int s_pct, input int r_pct);
        int bytes_start;
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
        bytes_start    = bytes_taken;
        while (bytes_taken - bytes_start < n_bytes)
            send_random_sample();
    endtask

    // Hold off the result side so the block fills and stalls its input
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = HOLD_CYCLES;
        repeat (8)
        begin
            put_header(16'd0, 8'h00, 8'h00);
            send_frame();
        end
        repeat (3) send_random_sample();
        wait_idle();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_stray_bytes();
        test_header_checks();
        test_packet_checks();
        test_entry_checks();
        test_restart_and_extremes();

        test_random_traffic(100, 0, 0);
        test_random_traffic(100, 60, 0);
        test_random_traffic(100, 0, 60);
        test_random_traffic(100, 36, 36);
        test_backpressure();
        test_random_traffic(50, 20, 20);

        wait_idle();
        repeat (DRAIN_TAIL) @(posedge clk);
        if (mismatch_count == 0)
            $display("rtp_hint_sample_validator_core_tb: PASS");
        else
            $display("rtp_hint_sample_validator_core_tb: FAIL");
        $finish;
    end

endmodule

/* rtp_hint_sample_validator_core.f */
rtl/core/rhsv_pkg.sv
rtl/core/rhsv_front.sv
rtl/core/rhsv_back.sv
rtl/core/rtp_hint_sample_validator_core.sv
tb/sv/rtp_hint_sample_validator_core_tb.sv
